### sv/urlfs_pkg.sv
// Shared types, codes and scheme constants for the URL field splitter.
package urlfs_pkg;

   typedef enum logic [2:0] {
      PH_SCHEME = 3'd0,
      PH_SEP1   = 3'd1,
      PH_SEP2   = 3'd2,
      PH_HOST   = 3'd3,
      PH_PORT   = 3'd4,
      PH_PATH   = 3'd5,
      PH_ERROR  = 3'd6
   } phase_type;

   localparam logic [2:0] TAG_SCHEME = 3'd0;
   localparam logic [2:0] TAG_SEP    = 3'd1;
   localparam logic [2:0] TAG_HOST   = 3'd2;
   localparam logic [2:0] TAG_COLON  = 3'd3;
   localparam logic [2:0] TAG_DIGIT  = 3'd4;
   localparam logic [2:0] TAG_PATH   = 3'd5;
   localparam logic [2:0] TAG_ERROR  = 3'd6;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_SEP    = 3'd1;
   localparam logic [2:0] ERR_ZERO   = 3'd2;
   localparam logic [2:0] ERR_SCHEME = 3'd3;
   localparam logic [2:0] ERR_PATH   = 3'd4;
   localparam logic [2:0] ERR_EMPTY  = 3'd5;
   localparam logic [2:0] ERR_EARLY  = 3'd6;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int NumSchemes = 4;

   typedef struct packed {
      logic [7:0] ch;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  byte_tag;
      logic        url_done;
      logic [15:0] port_value;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  scheme_len;
      logic [3:0]  match_flags;
      logic [15:0] port_acc;
      logic        digit_seen;
      logic [2:0]  err_latch;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:       PH_SCHEME,
      scheme_len:  3'd0,
      match_flags: 4'hF,
      port_acc:    16'd0,
      digit_seen:  1'b0,
      err_latch:   ERR_NONE
   };

   // 0 http, 1 https, 2 mysql, 3 ftp
   function automatic logic [2:0] scheme_len_of(input logic [1:0] k);
      logic [2:0] len;
      case (k)
         2'd0:    len = 3'd4;
         2'd1:    len = 3'd5;
         2'd2:    len = 3'd5;
         default: len = 3'd3;
      endcase
      return len;
   endfunction

   function automatic logic [15:0] scheme_port_of(input logic [1:0] k);
      logic [15:0] port;
      case (k)
         2'd0:    port = 16'd80;
         2'd1:    port = 16'd443;
         2'd2:    port = 16'd3306;
         default: port = 16'd21;
      endcase
      return port;
   endfunction

   // Character at position idx of scheme k; zero past its end.
   function automatic logic [7:0] scheme_char(input logic [1:0] k, input logic [2:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (k)
         2'd0: begin
            case (idx)
               3'd0:    c = 8'h68; // h
               3'd1:    c = 8'h74; // t
               3'd2:    c = 8'h74; // t
               3'd3:    c = 8'h70; // p
               default: c = 8'h00;
            endcase
         end
         2'd1: begin
            case (idx)
               3'd0:    c = 8'h68;
               3'd1:    c = 8'h74;
               3'd2:    c = 8'h74;
               3'd3:    c = 8'h70;
               3'd4:    c = 8'h73; // s
               default: c = 8'h00;
            endcase
         end
         2'd2: begin
            case (idx)
               3'd0:    c = 8'h6D; // m
               3'd1:    c = 8'h79; // y
               3'd2:    c = 8'h73; // s
               3'd3:    c = 8'h71; // q
               3'd4:    c = 8'h6C; // l
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0:    c = 8'h66; // f
               3'd1:    c = 8'h74; // t
               3'd2:    c = 8'h70; // p
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

### sv/urlfs_step.sv
// Per-byte parse step: next parser state and the result beat for one byte.
module urlfs_step (
   input  urlfs_pkg::parse_state_type cur,
   input  urlfs_pkg::req_type         beat,
   output urlfs_pkg::parse_state_type nxt,
   output urlfs_pkg::rsp_type         rsp
);

   logic        is_digit;
   logic [15:0] acc_mul;
   logic        dflt_hit;
   logic [15:0] dflt_port;
   logic [2:0]  tag;
   logic [15:0] port;
   logic [2:0]  err;
   urlfs_pkg::parse_state_type upd;

   assign is_digit = (beat.ch >= urlfs_pkg::CH_ZERO) && (beat.ch <= urlfs_pkg::CH_NINE);
   // acc*10 + digit, wraps at 16 bits
   assign acc_mul  = {cur.port_acc[12:0], 3'b000} + {cur.port_acc[14:0], 1'b0}
                   + {12'd0, beat.ch[3:0]};

   // First known scheme whose flag survived and whose length matches
   always_comb begin
      dflt_hit  = 1'b0;
      dflt_port = 16'd0;
      for (int k = urlfs_pkg::NumSchemes - 1; k >= 0; k--) begin
         if (cur.match_flags[k] && cur.scheme_len == urlfs_pkg::scheme_len_of(2'(k))) begin
            dflt_hit  = 1'b1;
            dflt_port = urlfs_pkg::scheme_port_of(2'(k));
         end
      end
   end

   always_comb begin
      upd = cur;
      tag = urlfs_pkg::TAG_ERROR;
      unique case (cur.phase)
         urlfs_pkg::PH_SCHEME: begin
            if (beat.ch == urlfs_pkg::CH_COLON) begin
               tag       = urlfs_pkg::TAG_SEP;
               upd.phase = urlfs_pkg::PH_SEP1;
            end else begin
               tag = urlfs_pkg::TAG_SCHEME;
               for (int k = 0; k < urlfs_pkg::NumSchemes; k++) begin
                  if (cur.scheme_len >= urlfs_pkg::scheme_len_of(2'(k)) ||
                      urlfs_pkg::scheme_char(2'(k), cur.scheme_len) != beat.ch)
                     upd.match_flags[k] = 1'b0;
               end
               if (cur.scheme_len != 3'd7)
                  upd.scheme_len = cur.scheme_len + 3'd1;
            end
         end
         urlfs_pkg::PH_SEP1, urlfs_pkg::PH_SEP2: begin
            if (beat.ch == urlfs_pkg::CH_SLASH) begin
               tag       = urlfs_pkg::TAG_SEP;
               upd.phase = (cur.phase == urlfs_pkg::PH_SEP1) ? urlfs_pkg::PH_SEP2
                                                              : urlfs_pkg::PH_HOST;
            end else begin
               upd.phase     = urlfs_pkg::PH_ERROR;
               upd.err_latch = urlfs_pkg::ERR_SEP;
            end
         end
         urlfs_pkg::PH_HOST: begin
            if (beat.ch == urlfs_pkg::CH_COLON) begin
               tag       = urlfs_pkg::TAG_COLON;
               upd.phase = urlfs_pkg::PH_PORT;
            end else if (beat.ch == urlfs_pkg::CH_SLASH) begin
               if (dflt_hit) begin
                  tag          = urlfs_pkg::TAG_PATH;
                  upd.phase    = urlfs_pkg::PH_PATH;
                  upd.port_acc = dflt_port;
               end else begin
                  upd.phase     = urlfs_pkg::PH_ERROR;
                  upd.err_latch = urlfs_pkg::ERR_SCHEME;
               end
            end else begin
               tag = urlfs_pkg::TAG_HOST;
            end
         end
         urlfs_pkg::PH_PORT: begin
            if (is_digit) begin
               upd.port_acc   = acc_mul;
               upd.digit_seen = 1'b1;
               if (acc_mul == 16'd0) begin
                  upd.phase     = urlfs_pkg::PH_ERROR;
                  upd.err_latch = urlfs_pkg::ERR_ZERO;
               end else begin
                  tag = urlfs_pkg::TAG_DIGIT;
               end
            end else if (!cur.digit_seen) begin
               upd.phase     = urlfs_pkg::PH_ERROR;
               upd.err_latch = urlfs_pkg::ERR_EMPTY;
            end else if (beat.ch == urlfs_pkg::CH_SLASH) begin
               tag       = urlfs_pkg::TAG_PATH;
               upd.phase = urlfs_pkg::PH_PATH;
            end else begin
               upd.phase     = urlfs_pkg::PH_ERROR;
               upd.err_latch = urlfs_pkg::ERR_PATH;
            end
         end
         urlfs_pkg::PH_PATH: tag = urlfs_pkg::TAG_PATH;
         default:            upd.phase = urlfs_pkg::PH_ERROR;
      endcase
   end

   // End-of-URL summary; scheme flags only move in the scheme phase, so the
   // default lookup on the current state still holds here.
   always_comb begin
      port = 16'd0;
      err  = urlfs_pkg::ERR_NONE;
      if (beat.final_byte) begin
         unique case (upd.phase)
            urlfs_pkg::PH_HOST: begin
               if (dflt_hit) port = dflt_port;
               else          err  = urlfs_pkg::ERR_SCHEME;
            end
            urlfs_pkg::PH_PORT: begin
               if (upd.digit_seen) port = upd.port_acc;
               else                err  = urlfs_pkg::ERR_EMPTY;
            end
            urlfs_pkg::PH_PATH:  port = upd.port_acc;
            urlfs_pkg::PH_ERROR: err  = upd.err_latch;
            default:             err  = urlfs_pkg::ERR_EARLY;
         endcase
         if (err != urlfs_pkg::ERR_NONE)
            port = 16'd0;
      end
   end

   assign nxt = beat.final_byte ? urlfs_pkg::STATE_RESET : upd;

   assign rsp.byte_tag   = tag;
   assign rsp.url_done   = beat.final_byte;
   assign rsp.port_value = port;
   assign rsp.error_code = err;

endmodule

### sv/url_field_splitter.sv
// Top level of the URL field splitter: input stage, parser state, result stage.
//
//  channel | ports                         | beat
//  --------+-------------------------------+-------------------------------
//  request | req_valid req_stall req_data  | one URL byte, last-byte flag
//  result  | rsp_valid rsp_stall rsp_data  | byte tag, done, port, error
//
// One byte per cycle sustained while the result side does not stall; a byte
// reaches rsp_data through the input register, then the parse step into the result register.
// The parser state updates as each byte moves into the result register.
// Reset clears both stage valids and returns the parser to the scheme phase.
// A result stall holds the result register, then backs up into req_stall.
module url_field_splitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  urlfs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output urlfs_pkg::rsp_type rsp_data
);

   logic                       in_valid_ff, in_valid_in;
   urlfs_pkg::req_type         in_beat_ff;
   logic                       out_valid_ff, out_valid_in;
   urlfs_pkg::rsp_type         out_beat_ff;
   urlfs_pkg::parse_state_type state_ff;
   urlfs_pkg::parse_state_type state_nxt;
   urlfs_pkg::rsp_type         step_rsp;
   logic                       out_free;
   logic                       advance;
   logic                       req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   urlfs_step u_step (
      .cur  (state_ff),
      .beat (in_beat_ff),
      .nxt  (state_nxt),
      .rsp  (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= urlfs_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance)
            state_ff <= state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_beat_ff <= req_data;
      if (advance)
         out_beat_ff <= step_rsp;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_beat_ff;

   // The last byte of a URL leaves the parser in its reset state
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      advance && in_beat_ff.final_byte |=> state_ff == urlfs_pkg::STATE_RESET)
      else $error("parser state not cleared after final byte");

   // Error phase always carries a latched cause
   a_error_latched: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == urlfs_pkg::PH_ERROR |-> state_ff.err_latch != urlfs_pkg::ERR_NONE)
      else $error("error phase without error code");

   // A failed URL reports no port; non-final beats report nothing
   a_rsp_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (!rsp_data.url_done || rsp_data.error_code != urlfs_pkg::ERR_NONE)
      |-> rsp_data.port_value == 16'd0)
      else $error("port reported alongside error or before end");

   // Input stage only pushes back when it holds a beat the result side refuses
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled without a blocked result");

   // A beat leaving the input stage lands in the result register
   a_beat_moves: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff && out_beat_ff.url_done == $past(in_beat_ff.final_byte))
      else $error("beat lost between stages");

endmodule

### sim/url_field_splitter_tb.sv
// Self-checking testbench for url_field_splitter: URL byte streams against a parse predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ByteTarget = 1900;
   localparam int CycleLimit = 200000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   urlfs_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   urlfs_pkg::rsp_type rsp_data;

   url_field_splitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Scheme table, bit k of the match mask tracks entry k
   string       scheme_names[4] = '{"http", "https", "mysql", "ftp"};
   logic [15:0] scheme_ports[4] = '{16'd80, 16'd443, 16'd3306, 16'd21};
   string       port_corners[6] = '{"65535", "65536", "0", "6553", "131072", "99999"};

   // Parser state mirrored by the predictor
   urlfs_pkg::phase_type cur_phase;
   logic [2:0]           name_len;
   logic [3:0]           name_hits;
   logic [15:0]          port_sum;
   logic                 have_digit;
   logic [2:0]           held_err;

   urlfs_pkg::req_type   pending_bytes[$];
   urlfs_pkg::rsp_type   expected_rsps[$];
   logic [7:0]           url_bytes[$];
   int                   mismatch_count = 0;
   int                   cycle_count = 0;

   function automatic void clear_parser();
      cur_phase  = urlfs_pkg::PH_SCHEME;
      name_len   = '0;
      name_hits  = 4'hF;
      port_sum   = '0;
      have_digit = 1'b0;
      held_err   = urlfs_pkg::ERR_NONE;
   endfunction

   function automatic bit scheme_default(output logic [15:0] port);
      bit found;
      found = 1'b0;
      port  = '0;
      for (int k = 0; k < 4; k++) begin
         if (!found && name_hits[k] && name_len == 3'(scheme_names[k].len())) begin
            found = 1'b1;
            port  = scheme_ports[k];
         end
      end
      return found;
   endfunction

   function automatic void enter_error(input logic [2:0] code);
      held_err  = code;
      cur_phase = urlfs_pkg::PH_ERROR;
   endfunction

   // Advances the parser by one byte and returns the result beat it should produce.
   function automatic urlfs_pkg::rsp_type parse_byte(input urlfs_pkg::req_type b);
      urlfs_pkg::rsp_type r;
      logic [15:0]        dport;
      bit                 is_digit;
      r = '0;
      r.byte_tag = urlfs_pkg::TAG_ERROR;
      is_digit = (b.ch >= urlfs_pkg::CH_ZERO) && (b.ch <= urlfs_pkg::CH_NINE);
      case (cur_phase)
         urlfs_pkg::PH_SCHEME: begin
            if (b.ch == urlfs_pkg::CH_COLON) begin
               r.byte_tag = urlfs_pkg::TAG_SEP;
               cur_phase  = urlfs_pkg::PH_SEP1;
            end else begin
               r.byte_tag = urlfs_pkg::TAG_SCHEME;
               for (int k = 0; k < 4; k++) begin
                  if (name_len >= 3'(scheme_names[k].len()) ||
                      8'(scheme_names[k][name_len]) != b.ch)
                     name_hits[k] = 1'b0;
               end
               if (name_len != 3'd7) name_len = name_len + 3'd1;
            end
         end
         urlfs_pkg::PH_SEP1, urlfs_pkg::PH_SEP2: begin
            if (b.ch == urlfs_pkg::CH_SLASH) begin
               r.byte_tag = urlfs_pkg::TAG_SEP;
               cur_phase  = (cur_phase == urlfs_pkg::PH_SEP1) ? urlfs_pkg::PH_SEP2
                                                             : urlfs_pkg::PH_HOST;
            end else begin
               enter_error(urlfs_pkg::ERR_SEP);
            end
         end
         urlfs_pkg::PH_HOST: begin
            if (b.ch == urlfs_pkg::CH_COLON) begin
               r.byte_tag = urlfs_pkg::TAG_COLON;
               cur_phase  = urlfs_pkg::PH_PORT;
            end else if (b.ch == urlfs_pkg::CH_SLASH) begin
               if (scheme_default(dport)) begin
                  port_sum   = dport;
                  r.byte_tag = urlfs_pkg::TAG_PATH;
                  cur_phase  = urlfs_pkg::PH_PATH;
               end else begin
                  enter_error(urlfs_pkg::ERR_SCHEME);
               end
            end else begin
               r.byte_tag = urlfs_pkg::TAG_HOST;
            end
         end
         urlfs_pkg::PH_PORT: begin
            if (is_digit) begin
               port_sum   = 16'(port_sum * 16'd10 + 16'(b.ch - urlfs_pkg::CH_ZERO));
               have_digit = 1'b1;
               if (port_sum == 16'd0) enter_error(urlfs_pkg::ERR_ZERO);
               else r.byte_tag = urlfs_pkg::TAG_DIGIT;
            end else if (!have_digit) begin
               enter_error(urlfs_pkg::ERR_EMPTY);
            end else if (b.ch == urlfs_pkg::CH_SLASH) begin
               r.byte_tag = urlfs_pkg::TAG_PATH;
               cur_phase  = urlfs_pkg::PH_PATH;
            end else begin
               enter_error(urlfs_pkg::ERR_PATH);
            end
         end
         urlfs_pkg::PH_PATH: begin
            r.byte_tag = urlfs_pkg::TAG_PATH;
         end
         default: begin
            cur_phase = urlfs_pkg::PH_ERROR;
         end
      endcase

      if (b.final_byte) begin
         r.url_done = 1'b1;
         case (cur_phase)
            urlfs_pkg::PH_HOST: begin
               if (scheme_default(dport)) r.port_value = dport;
               else r.error_code = urlfs_pkg::ERR_SCHEME;
            end
            urlfs_pkg::PH_PORT: begin
               if (have_digit) r.port_value = port_sum;
               else r.error_code = urlfs_pkg::ERR_EMPTY;
            end
            urlfs_pkg::PH_PATH:  r.port_value = port_sum;
            urlfs_pkg::PH_ERROR: r.error_code = held_err;
            default:             r.error_code = urlfs_pkg::ERR_EARLY;
         endcase
         if (r.error_code != urlfs_pkg::ERR_NONE) r.port_value = '0;
         clear_parser();
      end
      return r;
   endfunction

   // ---------------- stimulus construction ----------------

   task automatic add_byte(input logic [7:0] c);
      url_bytes.insert(url_bytes.size(), c);
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]));
   endtask

   task automatic flush_url();
      urlfs_pkg::req_type b;
      for (int i = 0; i < url_bytes.size(); i++) begin
         b.ch         = url_bytes[i];
         b.final_byte = (i == url_bytes.size() - 1);
         pending_bytes.insert(pending_bytes.size(), b);
      end
      url_bytes.delete();
   endtask

   function automatic logic [7:0] random_letter();
      return 8'($urandom_range(8'h7A, 8'h61));
   endfunction

   task automatic make_random_url();
      int    pick;
      int    n;
      string s;
      pick = $urandom_range(99);
      if (pick < 8) begin
         // pure noise
         n = $urandom_range(12, 1);
         repeat (n) add_byte(8'($urandom_range(255)));
      end else begin
         pick = $urandom_range(9);
         if (pick < 6) begin
            append_text(scheme_names[pick % 4]);
         end else if (pick == 6) begin
            append_text(scheme_names[$urandom_range(3)]);
            add_byte(random_letter());
         end else if (pick == 7) begin
            s = scheme_names[$urandom_range(3)];
            n = $urandom_range(s.len() - 1);
            if (n > 0) append_text(s.substr(0, n - 1));
         end else begin
            n = $urandom_range(10, 1);
            repeat (n) add_byte(random_letter());
         end

         pick = $urandom_range(99);
         if (pick < 90) begin
            append_text("://");
         end else if (pick < 95) begin
            append_text(":/");
            add_byte(8'($urandom_range(255)));
         end else begin
            append_text(":");
            add_byte(8'($urandom_range(255)));
         end

         n = $urandom_range(6);
         repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 75) add_byte(random_letter());
            else if (pick < 85) add_byte(8'h2E);
            else if (pick < 95)
               add_byte(8'($urandom_range(urlfs_pkg::CH_NINE, urlfs_pkg::CH_ZERO)));
            else add_byte(8'($urandom_range(255)));
         end

         if ($urandom_range(99) < 45) begin
            add_byte(urlfs_pkg::CH_COLON);
            if ($urandom_range(99) < 15) begin
               append_text(port_corners[$urandom_range(5)]);
            end else begin
               n = $urandom_range(5);
               repeat (n)
                  add_byte(8'($urandom_range(urlfs_pkg::CH_NINE, urlfs_pkg::CH_ZERO)));
            end
            if ($urandom_range(99) < 12) add_byte(random_letter());
         end

         if ($urandom_range(99) < 55) begin
            add_byte(urlfs_pkg::CH_SLASH);
            n = $urandom_range(8);
            repeat (n) add_byte(8'($urandom_range(255)));
         end

         // cut short now and then
         if ($urandom_range(99) < 10 && url_bytes.size() > 1) begin
            n = $urandom_range(url_bytes.size() - 1, 1);
            url_bytes = url_bytes[0:n-1];
         end
      end
      flush_url();
   endtask

   // ---------------- driver and monitor ----------------

   function automatic bit take_break();
      // the last third of each window runs without idling at all
      return ((cycle_count % 3000) < 2000) && ($urandom_range(99) < 7);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.insert(expected_rsps.size(), parse_byte(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && !take_break()) begin
               req_data  <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      urlfs_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_break();
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.byte_tag !== want.byte_tag)
                  report_mismatch($sformatf("byte_tag got %0d want %0d",
                                            rsp_data.byte_tag, want.byte_tag));
               if (rsp_data.url_done !== want.url_done)
                  report_mismatch($sformatf("url_done got %0d want %0d",
                                            rsp_data.url_done, want.url_done));
               if (rsp_data.port_value !== want.port_value)
                  report_mismatch($sformatf("port_value got %0d want %0d",
                                            rsp_data.port_value, want.port_value));
               if (rsp_data.error_code !== want.error_code)
                  report_mismatch($sformatf("error_code got %0d want %0d",
                                            rsp_data.error_code, want.error_code));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("url_field_splitter regression: fail");
         $finish;
      end
   end

   initial begin
      clear_parser();

      // directed: odd bytes, every error code, empty scheme and host
      add_byte(8'hFF);
      flush_url();
      append_text(":/");
      add_byte(8'h00);
      flush_url();
      append_text("://");
      flush_url();
      append_text("://:0");
      flush_url();
      append_text("://:");
      flush_url();
      append_text("://:9x");
      flush_url();
      append_text("ftp://");
      flush_url();

      while (pending_bytes.size() < ByteTarget) make_random_url();

      do @(posedge clock);
      while (reset || pending_bytes.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (6) @(posedge clock);

      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("url_field_splitter regression: pass");
      end else begin
         $display("url_field_splitter regression: fail");
      end
      $finish;
   end

endmodule
